// File: design/periodic_weighted_centroid_macros.svh
// Assertion macros for the periodic weighted centroid checker.
// Depends on nothing.
`ifndef PERIODIC_WEIGHTED_CENTROID_MACROS_SVH
`define PERIODIC_WEIGHTED_CENTROID_MACROS_SVH
`define PWC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PWC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: design/pwc_pkg.sv
// Package for the periodic weighted centroid: types, constants, state codes.
// Depends on nothing.
`default_nettype none
package pwc_pkg;
  localparam int unsigned MaxMembers = 65535;
  localparam logic [31:0] BoxReset = 32'h8000_0000;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] volume;
    logic        last_member;
  } in_item_t;

  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [15:0] member_count;
    logic        weight_zero;
  } out_item_t;

  // front-classified item: first flags a reference member
  typedef struct packed {
    in_item_t item;
    logic     first;
  } job_t;

  typedef enum logic [3:0] {
    StIdle, StWDiv, StMul, StAcc, StQDiv, StQFix, StCent, StOut
  } state_e;
endpackage
`default_nettype wire

// File: design/pwc_if.sv
// Valid/ready channel interfaces for input and result transactions.
// Depends on pwc_pkg.
`default_nettype none
interface pwc_in_if;
  logic valid;
  logic ready;
  pwc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pwc_out_if;
  logic valid;
  logic ready;
  pwc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/periodic_weighted_centroid.sv
// Top level of the periodic weighted centroid: box register, front, back.
// Depends on pwc_pkg, pwc_if, pwc_front, pwc_back.
//   channel  dir  payload
//   in_if    in   pos_x pos_y pos_z volume last_member
//   out_if   out  center_x center_y center_z member_count weight_zero
//   cfg      in   box_size (cfg_we_i, cfg_wdata_i)
// A member is handled in order: pop, a 64-step weight division, multiply and add per axis.
// A member with zero volume skips the division.
// A last member adds three 64-step quotient divisions with clamp and fold; with a zero
// total weight divisions and clamp are skipped; a stalled result holds the back end.
// Reset clears the queue, the group state and the box to 2^31.
// A two-entry queue takes transactions while the back end works or stalls, until full.
`default_nettype none
module periodic_weighted_centroid (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  pwc_in_if.sink           in_if,
  pwc_out_if.source        out_if
);
  logic [31:0] box_q;
  logic jv, jp;
  pwc_pkg::job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) box_q <= pwc_pkg::BoxReset;
    else if (cfg_we_i) box_q <= cfg_wdata_i;
  end

  pwc_front u_front (.clk_i, .rst_ni, .in_if, .job_valid_o(jv), .job_o(job),
                     .job_pop_i(jp));
  pwc_back u_back (.clk_i, .rst_ni, .box_i(box_q), .job_valid_i(jv), .job_i(job),
                   .job_pop_o(jp), .out_if);
endmodule
`default_nettype wire

// File: design/pwc_divider.sv
// Shared restoring divider, one quotient bit per cycle, 64 by 48 unsigned.
// Depends on nothing.
`default_nettype none
module pwc_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [47:0] den_i,
  output logic             done_o,
  output logic [63:0]      quot_o
);
  logic [63:0] quot_q, quot_d;
  logic [47:0] rem_q, rem_d;
  logic [47:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [48:0] trial;
  logic [48:0] diff;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[63]};
    diff   = trial - {1'b0, den_q};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = diff[47:0];
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = trial[47:0];
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = busy_q && (cnt_q == 7'd1);
  assign quot_o = quot_d;
endmodule
`default_nettype wire

// File: design/pwc_front.sv
// Front end: accepts input transactions, marks group references, fills a queue.
// Depends on pwc_pkg and pwc_if.
`default_nettype none
module pwc_front (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pwc_in_if.sink     in_if,
  output logic       job_valid_o,
  output pwc_pkg::job_t job_o,
  input  wire logic  job_pop_i
);
  localparam int unsigned Aw = $clog2(pwc_pkg::QueueDepth);
  pwc_pkg::job_t mem_q [pwc_pkg::QueueDepth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   fill_q;
  logic          open_q;
  logic          push;

  assign in_if.ready = (fill_q != (Aw+1)'(pwc_pkg::QueueDepth));
  assign push = in_if.valid && in_if.ready;
  assign job_valid_o = (fill_q != '0);
  assign job_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= '{item: in_if.data, first: !open_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      fill_q <= '0;
      open_q <= 1'b0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == Aw'(pwc_pkg::QueueDepth - 1)) ? '0 : wp_q + Aw'(1);
        open_q <= !in_if.data.last_member;
      end
      if (job_pop_i && job_valid_o)
        rp_q <= (rp_q == Aw'(pwc_pkg::QueueDepth - 1)) ? '0 : rp_q + Aw'(1);
      fill_q <= fill_q + (Aw+1)'(push) - (Aw+1)'(job_pop_i && job_valid_o);
    end
  end
endmodule
`default_nettype wire

// File: design/pwc_back.sv
// Back end: weight, folded offsets, saturating sums, centre computation.
// Depends on pwc_pkg, pwc_if and pwc_divider.
`default_nettype none
module pwc_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] box_i,
  input  wire logic        job_valid_i,
  input  pwc_pkg::job_t    job_i,
  output logic             job_pop_o,
  pwc_out_if.source        out_if
);
  pwc_pkg::state_e st_q, st_d;
  pwc_pkg::in_item_t it_q, it_d;
  logic [31:0] ref_q [3], ref_d [3];
  logic signed [63:0] sum_q [3], sum_d [3];
  logic signed [33:0] off_q [3], off_d [3];
  logic [47:0] wt_q, wt_d;
  logic [32:0] w_q, w_d;
  logic [15:0] cnt_q, cnt_d;
  logic [1:0]  ax_q, ax_d;
  logic signed [63:0] q_q, q_d;
  logic [31:0] cen_q [3], cen_d [3];
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;
  logic        ov_q, ov_d;
  logic [65:0] mag_q, mag_d;
  pwc_pkg::out_item_t res_q, res_d;
  logic        rv_q, rv_d;

  logic        dstart;
  logic [63:0] dnum;
  logic [47:0] dden;
  logic        ddone;
  logic [63:0] dquot;

  pwc_divider u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quot_o(dquot)
  );

  logic [31:0] pos_sel [3];
  logic signed [34:0] dd, bb;
  logic [32:0] omag;
  logic [48:0] prod;
  logic signed [64:0] sadd;
  logic signed [63:0] pv;
  logic [63:0] smag;
  logic signed [35:0] cc;

  assign pos_sel[0] = it_q.pos_x;
  assign pos_sel[1] = it_q.pos_y;
  assign pos_sel[2] = it_q.pos_z;
  assign out_if.valid = rv_q;
  assign out_if.data  = res_q;

  always_comb begin
    st_d = st_q; it_d = it_q; ref_d = ref_q; sum_d = sum_q; off_d = off_q;
    wt_d = wt_q; w_d = w_q; cnt_d = cnt_q; ax_d = ax_q; q_d = q_q; cen_d = cen_q;
    neg_d = neg_q; zero_d = zero_q; ov_d = ov_q; mag_d = mag_q;
    res_d = res_q; rv_d = rv_q;
    job_pop_o = 1'b0; dstart = 1'b0; dnum = 64'h1_0000_0000; dden = '0;
    dd = '0; bb = $signed({3'b0, box_i}); omag = '0; prod = '0; sadd = '0; pv = '0;
    smag = '0; cc = '0;
    if (rv_q && out_if.ready) rv_d = 1'b0;
    case (st_q)
      pwc_pkg::StIdle: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          it_d = job_i.item;
          if (job_i.first) begin
            ref_d[0] = job_i.item.pos_x;
            ref_d[1] = job_i.item.pos_y;
            ref_d[2] = job_i.item.pos_z;
            sum_d[0] = '0; sum_d[1] = '0; sum_d[2] = '0;
            wt_d = '0; cnt_d = '0;
          end
          dden = {16'b0, job_i.item.volume};
          if (job_i.item.volume != '0) begin
            dstart = 1'b1;
            st_d = pwc_pkg::StWDiv;
          end else begin
            w_d = '0;
            st_d = pwc_pkg::StMul;
          end
          ax_d = '0;
        end
      end
      pwc_pkg::StWDiv: begin
        for (int i = 0; i < 3; i++) begin
          dd = $signed({3'b0, pos_sel[i]}) - $signed({3'b0, ref_q[i]});
          if ((dd <<< 1) <= -bb) dd = dd + bb;
          else if ((dd <<< 1) > bb) dd = dd - bb;
          off_d[i] = dd[33:0];
        end
        if (ddone) begin
          w_d = dquot[32:0];
          st_d = pwc_pkg::StMul;
        end
      end
      pwc_pkg::StMul: begin
        omag = off_q[ax_q][33] ? 33'(-off_q[ax_q]) : off_q[ax_q][32:0];
        mag_d = {33'b0, omag} * {33'b0, w_q};
        neg_d = off_q[ax_q][33];
        st_d = pwc_pkg::StAcc;
      end
      pwc_pkg::StAcc: begin
        if (mag_q > 66'h0_7FFF_FFFF_FFFF_FFFF)
          pv = neg_q ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        else pv = neg_q ? -$signed(mag_q[63:0]) : $signed(mag_q[63:0]);
        sadd = $signed({sum_q[ax_q][63], sum_q[ax_q]}) + $signed({pv[63], pv});
        if (sadd[64] != sadd[63])
          sum_d[ax_q] = sadd[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        else sum_d[ax_q] = sadd[63:0];
        if (ax_q == 2'd2) begin
          prod = {1'b0, wt_q} + {16'b0, w_q};
          wt_d = prod[48] ? '1 : prod[47:0];
          if (cnt_q != 16'(pwc_pkg::MaxMembers)) cnt_d = cnt_q + 16'd1;
          ax_d = '0;
          if (it_q.last_member) begin
            zero_d = (prod == '0);
            st_d = pwc_pkg::StQDiv;
            ov_d = 1'b0;
          end else st_d = pwc_pkg::StIdle;
        end else begin
          ax_d = ax_q + 2'd1;
          st_d = pwc_pkg::StMul;
        end
      end
      pwc_pkg::StQDiv: begin
        smag = sum_q[ax_q][63] ? 64'(-sum_q[ax_q]) : sum_q[ax_q];
        neg_d = sum_q[ax_q][63];
        if (zero_q) begin
          q_d = '0;
          st_d = pwc_pkg::StCent;
        end else if (!ov_q) begin
          dnum = smag; dden = wt_q; dstart = 1'b1; ov_d = 1'b1;
        end else if (ddone) begin
          q_d = $signed(dquot);
          st_d = pwc_pkg::StQFix;
        end
      end
      pwc_pkg::StQFix: begin
        if (q_q[63:33] != '0 && q_q != 64'sh2_0000_0000) q_d = 64'sh2_0000_0000;
        if (neg_q) q_d = -q_d;
        st_d = pwc_pkg::StCent;
      end
      pwc_pkg::StCent: begin
        cc = $signed(q_q[35:0]) + $signed({4'b0, ref_q[ax_q]});
        if (cc <= 0) cc = cc + $signed({4'b0, box_i});
        else if (cc > $signed({4'b0, box_i})) cc = cc - $signed({4'b0, box_i});
        if (cc < 0) cen_d[ax_q] = '0;
        else if (cc[35:32] != '0) cen_d[ax_q] = '1;
        else cen_d[ax_q] = cc[31:0];
        ov_d = 1'b0;
        if (ax_q == 2'd2) st_d = pwc_pkg::StOut;
        else begin
          ax_d = ax_q + 2'd1;
          st_d = pwc_pkg::StQDiv;
        end
      end
      pwc_pkg::StOut: begin
        if (!rv_q || out_if.ready) begin
          res_d = '{center_x: cen_q[0], center_y: cen_q[1], center_z: cen_q[2],
                    member_count: cnt_q, weight_zero: zero_q};
          rv_d = 1'b1;
          st_d = pwc_pkg::StIdle;
        end
      end
      default: st_d = pwc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pwc_pkg::StIdle;
      rv_q <= 1'b0;
      ax_q <= '0;
      ov_q <= 1'b0;
      wt_q <= '0;
      cnt_q <= '0;
      for (int i = 0; i < 3; i++) begin
        ref_q[i] <= '0;
        sum_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      rv_q <= rv_d;
      ax_q <= ax_d;
      ov_q <= ov_d;
      wt_q <= wt_d;
      cnt_q <= cnt_d;
      ref_q <= ref_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; off_q <= off_d; w_q <= w_d; q_q <= q_d; cen_q <= cen_d;
    neg_q <= neg_d; zero_q <= zero_d; mag_q <= mag_d; res_q <= res_d;
  end
endmodule
`default_nettype wire

// File: design/pwc_checker.sv
// Port checker for the periodic weighted centroid, bound to the top level.
// Depends on pwc_pkg and the macros header.
`default_nettype none
`include "periodic_weighted_centroid_macros.svh"
module pwc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire pwc_pkg::out_item_t out_data
);
  `PWC_ASSERT(a_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped")
  `PWC_ASSERT(a_cnt, clk_i, rst_ni, out_valid |-> out_data.member_count != 16'd0, "zero count")
  `PWC_ASSERT(a_in_known, clk_i, rst_ni, in_valid |-> !$isunknown(in_ready), "input ready unknown")
  `PWC_ASSERT_NR(a_rst, clk_i, !rst_ni |-> !out_valid, "valid in reset")
endmodule

bind periodic_weighted_centroid pwc_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire
